// ----- hw/rtl/eqhc_pkg.sv -----
// eqhc_pkg: shared constants, types and helpers for the equatorial to
// horizontal conversion block (CORDIC arctangent table, fixed-point multiply).
// No dependencies.
`default_nettype none

package eqhc_pkg;

    // parameter defaults
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_STAGES        = 24;

    // fixed-point formats
    localparam int PHASE_W = 32;
    localparam int VEC_W   = 34;
    localparam int FRAC    = 30;
    localparam int LAT_W   = 15;
    localparam int LAT_MAG_W = 14;

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic [PHASE_W-1:0] phase_t;

    localparam vec_t ONE_V   = 34'sh0_4000_0000;
    localparam vec_t HALF_V  = 34'sh0_8000_0000;
    localparam vec_t GAIN_V  = 34'sd652032874;
    localparam phase_t PHASE_QUARTER = 32'h4000_0000;

    // latitude limit in hundredths of a degree
    localparam logic signed [LAT_W-1:0] LAT_LIMIT = 15'sd9000;

    // latitude to phase: m * 2^32 / 36000 = m * LAT_COEF + (m * LAT_REM + bias) / 1125
    localparam logic [29:0] LAT_COEF     = 30'd119304;
    localparam logic [22:0] LAT_REM      = 23'd728;
    localparam logic [22:0] LAT_BIAS     = 23'd562;
    localparam logic [22:0] LAT_RECIP    = 23'd7635498;
    localparam int          LAT_RECIP_SH = 33;

    // arctangent of 2^-i as a 32-bit phase
    function automatic vec_t atan_at(input int idx);
        vec_t r;
        case (idx)
            0:  r = 34'sd536870912;
            1:  r = 34'sd316933406;
            2:  r = 34'sd167458907;
            3:  r = 34'sd85004756;
            4:  r = 34'sd42667331;
            5:  r = 34'sd21354465;
            6:  r = 34'sd10679838;
            7:  r = 34'sd5340245;
            8:  r = 34'sd2670163;
            9:  r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            23: r = 34'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

    // product floored by 2^30
    function automatic vec_t fmul(input vec_t a, input vec_t b);
        logic signed [2*VEC_W-1:0] p;
        p = a * b;
        return p[FRAC+VEC_W-1:FRAC];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/eqhc_star_if.sv -----
// eqhc_star_if: request channel carrying one star position.
// Depends on eqhc_pkg.
`default_nettype none

interface eqhc_star_if
    import eqhc_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] declination;
    logic [ANGLE_BITS-1:0]        right_ascension;
    logic [ANGLE_BITS-1:0]        rete_rotation;

    modport source (output valid, declination, right_ascension, rete_rotation, input ready);
    modport sink   (input valid, declination, right_ascension, rete_rotation, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/eqhc_sky_if.sv -----
// eqhc_sky_if: request channel carrying one horizontal position.
// Depends on eqhc_pkg.
`default_nettype none

interface eqhc_sky_if
    import eqhc_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] altitude;
    logic signed [ANGLE_BITS-1:0] azimuth;

    modport source (output valid, altitude, azimuth, input ready);
    modport sink   (input valid, altitude, azimuth, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/equatorial_to_horizontal_convert_unit.sv -----
// equatorial_to_horizontal_convert_unit: star position to altitude and azimuth.
// Depends on eqhc_pkg, eqhc_star_if, eqhc_sky_if, eqhc_cordic_rot, eqhc_cordic_vec.
//
//   channel  role    payload
//   star     sink    declination, right_ascension, rete_rotation
//   sky      source  altitude, azimuth
//   cfg      write   cfg_wr_en, cfg_wr_data (observer latitude)
//
// One request per cycle while the sky channel is ready; requests pass through the
// three unrolled CORDIC chains in series (rotation, two vectoring).
// Reset clears the valid bits and sets the latitude to zero.
// Each stage advances when it is empty or its successor advances, so bubbles
// close up and a request is taken while a finished result waits.
`default_nettype none

module equatorial_to_horizontal_convert_unit
    import eqhc_pkg::*;
#(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    eqhc_star_if.sink              star,
    eqhc_sky_if.source             sky,
    input  wire logic              cfg_wr_en,
    input  wire logic [LAT_W-1:0]  cfg_wr_data
);

    localparam int N     = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    localparam int NR    = N + 2;
    localparam int NV    = N + 2;
    localparam int S_ROT = 3;
    localparam int S_M1  = S_ROT + NR;
    localparam int S_M2  = S_M1 + 1;
    localparam int S_M3  = S_M2 + 1;
    localparam int S_VA  = S_M3 + 1;
    localparam int S_VB  = S_VA + NV;
    localparam int S_OUT = S_VB + NV;
    localparam int T     = S_OUT + 1;
    localparam int SH    = PHASE_W - ANGLE_BITS;

    localparam logic signed [ANGLE_BITS-1:0] Q_POS = ANGLE_BITS'(1 << (ANGLE_BITS - 2));
    localparam logic signed [ANGLE_BITS-1:0] Q_NEG = -Q_POS;
    localparam logic signed [ANGLE_BITS:0]   QW_POS = (ANGLE_BITS+1)'(1 << (ANGLE_BITS - 2));
    localparam logic signed [ANGLE_BITS:0]   QW_NEG = -QW_POS;
    localparam logic [PHASE_W:0]             RND_W  = (PHASE_W+1)'(1 << (SH - 1));
    localparam phase_t                       RND_P  = PHASE_W'(1 << (SH - 1));

    // valid bits and stage enables
    logic [T-1:0] vld_reg;
    logic [T-1:0] ce;

    always_comb
    begin
        ce[T-1] = !vld_reg[T-1] || sky.ready;
        for (int k = T - 2; k >= 0; k--)
        begin
            ce[k] = !vld_reg[k] || ce[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ce[0])
            begin
                vld_reg[0] <= star.valid;
            end
            for (int k = 1; k < T; k++)
            begin
                if (ce[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign star.ready = ce[0];

    // latitude register, saturated on write
    logic signed [LAT_W-1:0] lat_reg;
    logic signed [LAT_W-1:0] lat_next;

    always_comb
    begin
        lat_next = signed'(cfg_wr_data);
        if (lat_next > LAT_LIMIT)
        begin
            lat_next = LAT_LIMIT;
        end
        else if (lat_next < -LAT_LIMIT)
        begin
            lat_next = -LAT_LIMIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lat_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            lat_reg <= lat_next;
        end
    end

    // stage 0: declination clamp, hour angle, latitude partial products
    logic signed [ANGLE_BITS-1:0] dec_c;
    logic [ANGLE_BITS-1:0]        ha_c;
    logic [LAT_MAG_W-1:0]         lat_abs;
    phase_t                       dec0_reg, dec1_reg, dec2_reg;
    phase_t                       ha0_reg, ha1_reg, ha2_reg;
    logic                         neg0_reg, neg1_reg;
    logic [29:0]                  mq0_reg, mq1_reg;
    logic [22:0]                  v0_reg;
    logic [12:0]                  q1_reg;
    phase_t                       th2_reg;
    logic [45:0]                  q_prod;
    logic [30:0]                  lat_mag;

    always_comb
    begin
        dec_c = star.declination;
        if (dec_c > Q_POS)
        begin
            dec_c = Q_POS;
        end
        else if (dec_c < Q_NEG)
        begin
            dec_c = Q_NEG;
        end
        ha_c    = star.right_ascension - star.rete_rotation;
        lat_abs = lat_reg[LAT_W-1] ? LAT_MAG_W'(-lat_reg) : LAT_MAG_W'(lat_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            dec0_reg <= phase_t'(unsigned'(dec_c)) << SH;
            ha0_reg  <= phase_t'(ha_c) << SH;
            neg0_reg <= lat_reg[LAT_W-1];
            mq0_reg  <= 30'(lat_abs) * LAT_COEF;
            v0_reg   <= 23'(lat_abs) * LAT_REM + LAT_BIAS;
        end
    end

    // stage 1: remainder divided by 1125 through its reciprocal
    assign q_prod = 46'(v0_reg) * 46'(LAT_RECIP);

    always_ff @(posedge clk)
    begin
        if (ce[1])
        begin
            dec1_reg <= dec0_reg;
            ha1_reg  <= ha0_reg;
            neg1_reg <= neg0_reg;
            mq1_reg  <= mq0_reg;
            q1_reg   <= q_prod[45:LAT_RECIP_SH];
        end
    end

    // stage 2: rotation angle, quarter turn minus latitude
    assign lat_mag = 31'(mq1_reg) + 31'(q1_reg);

    always_ff @(posedge clk)
    begin
        if (ce[2])
        begin
            dec2_reg <= dec1_reg;
            ha2_reg  <= ha1_reg;
            th2_reg  <= neg1_reg ? PHASE_QUARTER + phase_t'(lat_mag)
                                 : PHASE_QUARTER - phase_t'(lat_mag);
        end
    end

    // sines and cosines of declination, hour angle and rotation angle
    vec_t cd, sd, ch, shh, ct, st;

    eqhc_cordic_rot #(.STAGES(N)) u_rot_dec
    (
        .clk     (clk),
        .ce      (ce[S_ROT +: NR]),
        .phase   (dec2_reg),
        .cos_val (cd),
        .sin_val (sd)
    );

    eqhc_cordic_rot #(.STAGES(N)) u_rot_ha
    (
        .clk     (clk),
        .ce      (ce[S_ROT +: NR]),
        .phase   (ha2_reg),
        .cos_val (ch),
        .sin_val (shh)
    );

    eqhc_cordic_rot #(.STAGES(N)) u_rot_th
    (
        .clk     (clk),
        .ce      (ce[S_ROT +: NR]),
        .phase   (th2_reg),
        .cos_val (ct),
        .sin_val (st)
    );

    // unit vector
    vec_t x1_reg, y1_reg, z1_reg, ct1_reg, st1_reg;

    always_ff @(posedge clk)
    begin
        if (ce[S_M1])
        begin
            x1_reg  <= fmul(cd, ch);
            y1_reg  <= fmul(cd, shh);
            z1_reg  <= sd;
            ct1_reg <= ct;
            st1_reg <= st;
        end
    end

    // rotation about the x axis, products
    vec_t x2_reg, p1_reg, p2_reg, p3_reg, p4_reg;

    always_ff @(posedge clk)
    begin
        if (ce[S_M2])
        begin
            x2_reg <= x1_reg;
            p1_reg <= fmul(y1_reg, ct1_reg);
            p2_reg <= fmul(z1_reg, st1_reg);
            p3_reg <= fmul(y1_reg, st1_reg);
            p4_reg <= fmul(z1_reg, ct1_reg);
        end
    end

    // rotation about the x axis, sums
    vec_t x3_reg, y3_reg, z3_reg;

    always_ff @(posedge clk)
    begin
        if (ce[S_M3])
        begin
            x3_reg <= x2_reg;
            y3_reg <= p1_reg - p2_reg;
            z3_reg <= p3_reg + p4_reg;
        end
    end

    // azimuth and horizontal magnitude
    phase_t az_ph;
    vec_t   r_mag;
    vec_t   z_dly_reg [NV];

    eqhc_cordic_vec #(.STAGES(N)) u_vec_az
    (
        .clk   (clk),
        .ce    (ce[S_VA +: NV]),
        .x_in  (x3_reg),
        .y_in  (y3_reg),
        .phase (az_ph),
        .mag   (r_mag)
    );

    for (genvar k = 0; k < NV; k++)
    begin : g_zdly
        always_ff @(posedge clk)
        begin
            if (ce[S_VA+k])
            begin
                z_dly_reg[k] <= (k == 0) ? z3_reg : z_dly_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // altitude
    phase_t alt_ph;
    vec_t   alt_mag_unused;
    phase_t az_dly_reg [NV];

    eqhc_cordic_vec #(.STAGES(N)) u_vec_alt
    (
        .clk   (clk),
        .ce    (ce[S_VB +: NV]),
        .x_in  (r_mag),
        .y_in  (z_dly_reg[NV-1]),
        .phase (alt_ph),
        .mag   (alt_mag_unused)
    );

    for (genvar k = 0; k < NV; k++)
    begin : g_azdly
        always_ff @(posedge clk)
        begin
            if (ce[S_VB+k])
            begin
                az_dly_reg[k] <= (k == 0) ? az_ph : az_dly_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // round both phases to output width, clamp altitude
    logic [PHASE_W:0]             alt_sum;
    logic signed [ANGLE_BITS:0]   alt_w;
    logic signed [ANGLE_BITS-1:0] alt_next;
    phase_t                       az_sum;
    logic signed [ANGLE_BITS-1:0] alt_reg;
    logic signed [ANGLE_BITS-1:0] az_reg;

    always_comb
    begin
        alt_sum = {alt_ph[PHASE_W-1], alt_ph} + RND_W;
        alt_w   = signed'(alt_sum[PHASE_W:SH]);
        if (alt_w > QW_POS)
        begin
            alt_next = Q_POS;
        end
        else if (alt_w < QW_NEG)
        begin
            alt_next = Q_NEG;
        end
        else
        begin
            alt_next = alt_w[ANGLE_BITS-1:0];
        end
        az_sum = az_dly_reg[NV-1] + RND_P;
    end

    always_ff @(posedge clk)
    begin
        if (ce[S_OUT])
        begin
            alt_reg <= alt_next;
            az_reg  <= signed'(az_sum[PHASE_W-1:SH]);
        end
    end

    assign sky.valid    = vld_reg[T-1];
    assign sky.altitude = alt_reg;
    assign sky.azimuth  = az_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/eqhc_cordic_rot.sv -----
// eqhc_cordic_rot: unrolled rotation-mode CORDIC, phase in, cosine and sine out.
// Depends on eqhc_pkg. Stage enables come from the owner of the valid bits.
`default_nettype none

module eqhc_cordic_rot
    import eqhc_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF
)
(
    input  wire logic            clk,
    input  wire logic [STAGES+1:0] ce,
    input  wire phase_t          phase,
    output vec_t                 cos_val,
    output vec_t                 sin_val
);

    vec_t x_reg [STAGES+1];
    vec_t y_reg [STAGES+1];
    vec_t z_reg [STAGES+1];
    logic neg_reg [STAGES+1];
    vec_t cos_reg;
    vec_t sin_reg;

    vec_t z0_next;
    logic neg0_next;

    // fold the phase into plus or minus a quarter turn
    always_comb
    begin
        z0_next   = vec_t'(signed'(phase));
        neg0_next = 1'b0;
        if (z0_next > ONE_V)
        begin
            z0_next   = z0_next - HALF_V;
            neg0_next = 1'b1;
        end
        else if (z0_next < -ONE_V)
        begin
            z0_next   = z0_next + HALF_V;
            neg0_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            x_reg[0]   <= GAIN_V;
            y_reg[0]   <= '0;
            z_reg[0]   <= z0_next;
            neg_reg[0] <= neg0_next;
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        vec_t dx;
        vec_t dy;
        vec_t x_next;
        vec_t y_next;
        vec_t z_next;

        always_comb
        begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            if (!z_reg[i][VEC_W-1])
            begin
                x_next = x_reg[i] - dx;
                y_next = y_reg[i] + dy;
                z_next = z_reg[i] - atan_at(i);
            end
            else
            begin
                x_next = x_reg[i] + dx;
                y_next = y_reg[i] - dy;
                z_next = z_reg[i] + atan_at(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce[i+1])
            begin
                x_reg[i+1]   <= x_next;
                y_reg[i+1]   <= y_next;
                z_reg[i+1]   <= z_next;
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    // undo the fold
    always_ff @(posedge clk)
    begin
        if (ce[STAGES+1])
        begin
            cos_reg <= neg_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];
            sin_reg <= neg_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES];
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/eqhc_cordic_vec.sv -----
// eqhc_cordic_vec: unrolled vectoring-mode CORDIC, gives atan2(y, x) as a
// 32-bit phase and the gain-corrected magnitude. Depends on eqhc_pkg.
`default_nettype none

module eqhc_cordic_vec
    import eqhc_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF
)
(
    input  wire logic              clk,
    input  wire logic [STAGES+1:0] ce,
    input  wire vec_t              x_in,
    input  wire vec_t              y_in,
    output phase_t                 phase,
    output vec_t                   mag
);

    vec_t x_reg [STAGES+1];
    vec_t y_reg [STAGES+1];
    vec_t z_reg [STAGES+1];
    logic half_reg [STAGES+1];
    logic zero_reg [STAGES+1];
    phase_t phase_reg;
    vec_t   mag_reg;

    // move the vector into the right half plane, flag the null vector
    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            half_reg[0] <= x_in[VEC_W-1];
            x_reg[0]    <= x_in[VEC_W-1] ? -x_in : x_in;
            y_reg[0]    <= x_in[VEC_W-1] ? -y_in : y_in;
            z_reg[0]    <= '0;
        end
    end

    // one micro-rotation per stage toward the x axis
    for (genvar i = 0; i < STAGES; i++)
    begin : g_iter
        vec_t dx;
        vec_t dy;
        vec_t x_next;
        vec_t y_next;
        vec_t z_next;

        always_comb
        begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            if (!y_reg[i][VEC_W-1] && (y_reg[i] != '0))
            begin
                x_next = x_reg[i] + dx;
                y_next = y_reg[i] - dy;
                z_next = z_reg[i] + atan_at(i);
            end
            else
            begin
                x_next = x_reg[i] - dx;
                y_next = y_reg[i] + dy;
                z_next = z_reg[i] - atan_at(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce[i+1])
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                half_reg[i+1] <= half_reg[i];
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // gain correction and half-turn offset
    always_ff @(posedge clk)
    begin
        if (ce[STAGES+1])
        begin
            if (zero_reg[STAGES])
            begin
                phase_reg <= '0;
                mag_reg   <= '0;
            end
            else
            begin
                phase_reg <= {half_reg[STAGES], {(PHASE_W-1){1'b0}}}
                             + phase_t'(z_reg[STAGES][PHASE_W-1:0]);
                mag_reg   <= fmul(x_reg[STAGES], GAIN_V);
            end
        end
    end

    assign phase = phase_reg;
    assign mag   = mag_reg;

endmodule

`default_nettype wire

// ----- tb/tb_equatorial_to_horizontal_convert_unit.sv -----
// tb_equatorial_to_horizontal_convert_unit: self-checking bench for the star to sky conversion.
// Drives star requests through a queue-fed driver and checks each sky request against a
// fixed-point CORDIC predictor. Depends on eqhc_pkg, eqhc_star_if, eqhc_sky_if and the unit.
`timescale 1ns / 100ps

module tb_equatorial_to_horizontal_convert_unit;
    import eqhc_pkg::*;

    localparam int LATENCY = 3 * 16 + 13;
    localparam int STAGES  = 16;

    typedef struct packed {
        logic [15:0] declination;
        logic [15:0] right_ascension;
        logic [15:0] rete_rotation;
    } star_req_t;

    typedef struct packed {
        logic [15:0] altitude;
        logic [15:0] azimuth;
    } sky_pos_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [LAT_W-1:0] cfg_wr_data;

    eqhc_star_if star ();
    eqhc_sky_if  sky ();

    equatorial_to_horizontal_convert_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .star        (star),
        .sky         (sky),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    star_req_t   pending_stars[$];
    sky_pos_t    expected_sky[$];
    longint      latitude_cur;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_off_cycles;
    int          error_count;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // arithmetic shift right, floor
    function automatic longint shr_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint mul_q30(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic longint atan_step(input int i);
        longint tbl[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722,
            20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
        return tbl[i];
    endfunction

    function automatic longint phase_to_signed(input logic [31:0] p);
        return p[31] ? longint'(p) - 64'sd4294967296 : longint'(p);
    endfunction

    // rotation-mode cordic: cosine and sine of a phase
    function automatic void rotate_phase(input logic [31:0] ph, output longint c,
                                         output longint s);
        longint z, x, y, dx, dy;
        bit flip;
        z = phase_to_signed(ph);
        x = 652032874;
        y = 0;
        flip = 0;
        if (z > 64'sd1073741824)
        begin
            z -= 64'sd2147483648;
            flip = 1;
        end
        else if (z < -64'sd1073741824)
        begin
            z += 64'sd2147483648;
            flip = 1;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // vectoring-mode cordic: angle and magnitude of (x, y)
    function automatic void vector_angle(input longint yi, input longint xi,
                                         output logic [31:0] ang, output longint mag);
        longint x, y, z, dx, dy;
        logic [31:0] base;
        x = xi; y = yi; z = 0; base = '0;
        if (x == 0 && y == 0)
        begin
            mag = 0;
            ang = '0;
        end
        else
        begin
            if (x < 0)
            begin
                x = -x; y = -y; base = 32'h8000_0000;
            end
            for (int i = 0; i < STAGES; i++)
            begin
                dx = shr_floor(y, i);
                dy = shr_floor(x, i);
                if (y > 0)
                begin
                    x += dx; y -= dy; z += atan_step(i);
                end
                else
                begin
                    x -= dx; y += dy; z -= atan_step(i);
                end
            end
            mag = mul_q30(x, 652032874);
            ang = base + z[31:0];
        end
    endfunction

    // predicted altitude and azimuth for one star at the current latitude
    function automatic sky_pos_t predict_sky(input star_req_t s);
        longint dec, lat_mag, lat_ph, cd, sd, ch, sh, ct, st;
        longint x, y, z, y2, z2, r, unused_mag, alt;
        logic [31:0] dec_ph, ha_ph, th_ph, alt_ph, az_ph;
        logic [15:0] ha;
        logic [31:0] az_round;
        sky_pos_t res;
        dec = longint'(signed'(s.declination));
        if (dec > 16384) dec = 16384;
        if (dec < -16384) dec = -16384;
        dec_ph = 32'(dec) << 16;
        ha = s.right_ascension - s.rete_rotation;
        ha_ph = {ha, 16'h0};
        lat_mag = latitude_cur < 0 ? -latitude_cur : latitude_cur;
        lat_mag = (lat_mag * 64'sd4294967296 + 18000) / 36000;
        lat_ph = latitude_cur < 0 ? -lat_mag : lat_mag;
        th_ph = 32'(64'sd1073741824 - lat_ph);
        rotate_phase(dec_ph, cd, sd);
        rotate_phase(ha_ph, ch, sh);
        rotate_phase(th_ph, ct, st);
        x = mul_q30(cd, ch);
        y = mul_q30(cd, sh);
        z = sd;
        y2 = mul_q30(y, ct) - mul_q30(z, st);
        z2 = mul_q30(y, st) + mul_q30(z, ct);
        vector_angle(y2, x, az_ph, r);
        vector_angle(z2, r, alt_ph, unused_mag);
        alt = (phase_to_signed(alt_ph) + 32768) >>> 16;
        if (alt > 16384) alt = 16384;
        if (alt < -16384) alt = -16384;
        az_round = az_ph + 32'h8000;
        res.altitude = alt[15:0];
        res.azimuth = az_round[31:16];
        return res;
    endfunction

    // star driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            star.valid <= 1'b0;
        end
        else if (!star.valid || star.ready)
        begin
            if (pending_stars.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                star_req_t s;
                s = pending_stars.pop_front();
                star.valid <= 1'b1;
                star.declination <= s.declination;
                star.right_ascension <= s.right_ascension;
                star.rete_rotation <= s.rete_rotation;
                expected_sky.push_back(predict_sky(s));
            end
            else
            begin
                star.valid <= 1'b0;
            end
        end
    end

    // sky ready, with optional long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sky.ready <= 1'b0;
        end
        else if (hold_off_cycles > 0)
        begin
            sky.ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
        begin
            sky.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // sky monitor
    always @(posedge clk)
    begin
        if (rst_n && sky.valid && sky.ready)
        begin
            if (expected_sky.size() == 0)
            begin
                $display("%0t: unexpected sky request alt %0d az %0d", $time,
                         sky.altitude, sky.azimuth);
                error_count++;
            end
            else
            begin
                sky_pos_t e;
                e = expected_sky.pop_front();
                if (sky.altitude !== e.altitude)
                begin
                    $display("%0t: altitude expected %0d actual %0d", $time,
                             $signed(e.altitude), sky.altitude);
                    error_count++;
                end
                if (sky.azimuth !== e.azimuth)
                begin
                    $display("%0t: azimuth expected %0d actual %0d", $time,
                             $signed(e.azimuth), sky.azimuth);
                    error_count++;
                end
            end
        end
    end

    // latitude write while idle
    task automatic write_latitude(input logic [14:0] v);
        longint s;
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        s = longint'(signed'(v));
        if (s > 9000) s = 9000;
        if (s < -9000) s = -9000;
        latitude_cur = s;
    endtask

    task automatic wait_drained();
        while (pending_stars.size() > 0 || star.valid || expected_sky.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    function automatic star_req_t random_star();
        star_req_t s;
        s.right_ascension = 16'($urandom);
        s.rete_rotation = 16'($urandom);
        case ($urandom_range(9))
            0: s.declination = 16'($urandom);
            1: s.declination = ($urandom_range(1)) ? 16'sd16384 : -16'sd16384;
            default: s.declination = 16'($urandom_range(32768) - 16384);
        endcase
        if ($urandom_range(19) == 0) s.rete_rotation = s.right_ascension;
        return s;
    endfunction

    function automatic star_req_t mk(input logic [15:0] d, input logic [15:0] ra,
                                     input logic [15:0] rr);
        star_req_t s;
        s.declination = d;
        s.right_ascension = ra;
        s.rete_rotation = rr;
        return s;
    endfunction

    // stimulus
    initial
    begin
        logic [14:0] lat_set[7] = '{15'sd9000, -15'sd9000, 15'h3fff, 15'h4000, 15'sd4500,
                                    -15'sd3333, 15'sd0};
        star.valid = 1'b0;
        star.declination = '0;
        star.right_ascension = '0;
        star.rete_rotation = '0;
        sky.ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        latitude_cur = 0;
        send_idle_pct = 17;
        recv_idle_pct = 55;
        hold_off_cycles = 0;
        error_count = 0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, poles, saturation, zenith and wrap cases
        pending_stars.push_back(mk(16'sd0, 16'd0, 16'd0));
        pending_stars.push_back(mk(16'sd16384, 16'd0, 16'd0));
        pending_stars.push_back(mk(-16'sd16384, 16'd123, 16'd0));
        pending_stars.push_back(mk(16'h7fff, 16'hffff, 16'h0000));
        pending_stars.push_back(mk(16'h8000, 16'h0000, 16'hffff));
        pending_stars.push_back(mk(16'sd0, 16'd32768, 16'd0));
        pending_stars.push_back(mk(16'sd0, 16'd16384, 16'd0));
        pending_stars.push_back(mk(16'sd0, 16'd49152, 16'd0));
        pending_stars.push_back(mk(16'sd0, 16'hffff, 16'hffff));
        pending_stars.push_back(mk(16'sd8192, 16'h5555, 16'haaaa));
        pending_stars.push_back(mk(-16'sd1, 16'haaaa, 16'h5555));
        wait_drained();
        write_latitude(15'sd9000);
        pending_stars.push_back(mk(16'sd16384, 16'd0, 16'd0));
        pending_stars.push_back(mk(16'sd0, 16'd0, 16'd0));
        pending_stars.push_back(mk(-16'sd16384, 16'd777, 16'd3));
        wait_drained();
        write_latitude(-15'sd9000);
        pending_stars.push_back(mk(-16'sd16384, 16'd0, 16'd0));
        pending_stars.push_back(mk(16'sd0, 16'd32768, 16'd0));
        wait_drained();

        // random phases across latitude settings and idle patterns
        for (int ph = 0; ph < 7; ph++)
        begin
            write_latitude(ph == 6 ? 15'($urandom) : lat_set[ph]);
            if (ph == 2)
            begin
                send_idle_pct = 55;
                recv_idle_pct = 17;
            end
            if (ph == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 5)
                hold_off_cycles = 300;
            repeat (240) pending_stars.push_back(random_star());
            // sender pauses until every result is back
            wait_drained();
        end

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial
    begin
        #(12 * 400000);
        $display("tb: failure");
        $finish;
    end

endmodule
